// ----- rtl/core/artnet_dmx_to_pixel_parser_top_defines.svh -----
// Assertion helpers shared by the RTL.
`ifndef ARTNET_DMX_TO_PIXEL_PARSER_TOP_DEFINES_SVH
`define ARTNET_DMX_TO_PIXEL_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define ARTDMX_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ARTDMX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/artdmx_pkg.sv -----
package artdmx_pkg;

    localparam int unsigned PIXEL_COUNT_DEF = 300;
    localparam int unsigned SPLIT_DEF       = 170;
    localparam int unsigned MAX_FRAME_DEF   = 1500;

    localparam int unsigned POS_W   = 11;
    localparam int unsigned PIX_W   = 9;
    localparam int unsigned UNIV_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [POS_W-1:0] POS_MAX     = '1;
    localparam logic [PIX_W-1:0] COUNTER_MAX = '1;

    localparam logic [POS_W-1:0] POS_ID_LEN     = POS_W'(8);
    localparam logic [POS_W-1:0] POS_OPCODE_LO  = POS_W'(8);
    localparam logic [POS_W-1:0] POS_OPCODE_HI  = POS_W'(9);
    localparam logic [POS_W-1:0] POS_UNIV_LO    = POS_W'(14);
    localparam logic [POS_W-1:0] POS_UNIV_HI    = POS_W'(15);
    localparam logic [POS_W-1:0] POS_DATA_START = POS_W'(18);

    localparam logic [15:0] OPC_ARTDMX = 16'h5000;
    localparam logic [15:0] OP_POLL    = 16'h2000;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNIVERSE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_UNIVERSE = 1'b1;

    localparam logic [UNIV_W-1:0] FIRST_UNIVERSE_RST  = 16'd1;
    localparam logic [UNIV_W-1:0] SECOND_UNIVERSE_RST = 16'd2;

    localparam logic [1:0] PHASE_RED   = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_BLUE  = 2'd2;

    localparam logic [BYTE_W-1:0] ART_ID [8] = '{
        8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74, 8'h00
    };

    typedef enum logic {
        EV_PIXEL = 1'b0,
        EV_POLL  = 1'b1
    } event_kind_t;

    typedef struct packed {
        event_kind_t       event_kind;
        logic [PIX_W-1:0]  pixel_index;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } result_t;

endpackage

// ----- rtl/core/artnet_dmx_to_pixel_parser_top.sv -----
// Art-Net receive parser: takes one UDP payload byte per transfer, checks the
// "Art-Net" ID, and turns ArtDMX (OpOutput) data of the two configured
// universes into pixel writes (one per RGB triplet) and an ArtPoll datagram
// into a poll event on its last byte. A byte is accepted every clock while the
// skid entry is empty; its result, if any, is registered in the output register
// or the skid entry. A two-entry output buffer lets input keep flowing while one
// result waits on m_ready. Write the universe registers only while idle.
`include "artnet_dmx_to_pixel_parser_top_defines.svh"

module artnet_dmx_to_pixel_parser_top #(
    parameter int unsigned PIXEL_COUNT = artdmx_pkg::PIXEL_COUNT_DEF,
    parameter int unsigned SPLIT       = artdmx_pkg::SPLIT_DEF,
    parameter int unsigned MAX_FRAME   = artdmx_pkg::MAX_FRAME_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [artdmx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [artdmx_pkg::UNIV_W-1:0]    cfg_wr_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [artdmx_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic                             s_last_byte,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_event_kind,
    output logic [artdmx_pkg::PIX_W-1:0]     m_pixel_index,
    output logic [artdmx_pkg::BYTE_W-1:0]    m_red,
    output logic [artdmx_pkg::BYTE_W-1:0]    m_green,
    output logic [artdmx_pkg::BYTE_W-1:0]    m_blue
);
    import artdmx_pkg::*;

    logic [UNIV_W-1:0] first_univ_reg, second_univ_reg;

    logic    in_xfer;
    logic    res_valid;
    result_t res;

    logic    main_valid_reg, main_valid_next;
    result_t main_reg, main_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_reg, skid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_univ_reg  <= FIRST_UNIVERSE_RST;
            second_univ_reg <= SECOND_UNIVERSE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FIRST_UNIVERSE:  first_univ_reg  <= cfg_wr_data;
                REG_SECOND_UNIVERSE: second_univ_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign s_ready = !skid_valid_reg;
    assign in_xfer = s_valid && s_ready;

    artdmx_parse #(
        .PIXEL_COUNT (PIXEL_COUNT),
        .SPLIT       (SPLIT),
        .MAX_FRAME   (MAX_FRAME)
    ) u_parse (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_xfer         (in_xfer),
        .data_byte       (s_data_byte),
        .last_byte       (s_last_byte),
        .first_universe  (first_univ_reg),
        .second_universe (second_univ_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    always_comb begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else if (res_valid) begin
                main_valid_next = 1'b1;
                main_next       = res;
            end else begin
                main_valid_next = 1'b0;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_valid       = main_valid_reg;
    assign m_event_kind  = main_reg.event_kind;
    assign m_pixel_index = main_reg.pixel_index;
    assign m_red         = main_reg.red;
    assign m_green       = main_reg.green;
    assign m_blue        = main_reg.blue;

    `ARTDMX_ASSERT_NOW(a_skid_implies_main, aclk, aresetn,
        skid_valid_reg, main_valid_reg)
    `ARTDMX_ASSERT_NOW(a_poll_payload_zero, aclk, aresetn,
        m_valid && (m_event_kind == EV_POLL),
        (m_pixel_index == '0) && (m_red == '0) && (m_green == '0) && (m_blue == '0))
    `ARTDMX_ASSERT_NOW(a_pixel_in_range, aclk, aresetn,
        m_valid && (m_event_kind == EV_PIXEL),
        (PIX_W+1)'(m_pixel_index) < (PIX_W+1)'(PIXEL_COUNT))
    `ARTDMX_ASSERT_NEXT(a_skid_holds, aclk, aresetn,
        skid_valid_reg && !m_ready, skid_valid_reg && main_valid_reg)

endmodule

// ----- rtl/core/artdmx_parse.sv -----
module artdmx_parse #(
    parameter int unsigned PIXEL_COUNT = artdmx_pkg::PIXEL_COUNT_DEF,
    parameter int unsigned SPLIT       = artdmx_pkg::SPLIT_DEF,
    parameter int unsigned MAX_FRAME   = artdmx_pkg::MAX_FRAME_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_xfer,
    input  logic [artdmx_pkg::BYTE_W-1:0] data_byte,
    input  logic                          last_byte,
    input  logic [artdmx_pkg::UNIV_W-1:0] first_universe,
    input  logic [artdmx_pkg::UNIV_W-1:0] second_universe,
    output logic                          res_valid,
    output artdmx_pkg::result_t           res
);
    import artdmx_pkg::*;

    localparam logic [POS_W-1:0] MAX_FRAME_P   = POS_W'(MAX_FRAME);
    localparam logic [PIX_W:0]   SPLIT_P       = (PIX_W+1)'(SPLIT);
    localparam logic [PIX_W:0]   PIXEL_COUNT_P = (PIX_W+1)'(PIXEL_COUNT);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              hdr_ok_reg, hdr_ok_next;
    logic [15:0]       opcode_reg, opcode_next;
    logic [UNIV_W-1:0] univ_reg, univ_next;
    logic [1:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] red_reg, red_next;
    logic [BYTE_W-1:0] green_reg, green_next;
    logic [PIX_W-1:0]  pix_cnt_reg, pix_cnt_next;

    logic              in_data;
    logic              hit;
    logic              poll;
    logic [PIX_W-1:0]  hit_idx;
    logic [PIX_W:0]    second_idx;

    assign in_data = (pos_reg >= POS_DATA_START) && (pos_reg < MAX_FRAME_P)
                     && hdr_ok_reg && (opcode_reg == OPC_ARTDMX);
    assign second_idx = SPLIT_P + {1'b0, pix_cnt_reg};

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        if (univ_reg == first_universe) begin
            if ({1'b0, pix_cnt_reg} < SPLIT_P) begin
                hit     = 1'b1;
                hit_idx = pix_cnt_reg;
            end
        end else if (univ_reg == second_universe) begin
            if (second_idx < PIXEL_COUNT_P) begin
                hit     = 1'b1;
                hit_idx = second_idx[PIX_W-1:0];
            end
        end
    end

    always_comb begin
        pos_next     = pos_reg;
        hdr_ok_next  = hdr_ok_reg;
        opcode_next  = opcode_reg;
        univ_next    = univ_reg;
        phase_next   = phase_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        pix_cnt_next = pix_cnt_reg;
        res_valid    = 1'b0;
        poll         = 1'b0;
        res          = '{event_kind: EV_PIXEL, pixel_index: '0,
                         red: '0, green: '0, blue: '0};
        if (in_xfer) begin
            if (pos_reg < POS_ID_LEN) begin
                if (data_byte != ART_ID[pos_reg[2:0]]) begin
                    hdr_ok_next = 1'b0;
                end
            end else if (pos_reg == POS_OPCODE_LO) begin
                opcode_next[7:0] = data_byte;
            end else if (pos_reg == POS_OPCODE_HI) begin
                opcode_next[15:8] = data_byte;
            end else if (pos_reg == POS_UNIV_LO) begin
                univ_next[7:0] = data_byte;
            end else if (pos_reg == POS_UNIV_HI) begin
                univ_next[15:8] = data_byte;
            end else if (in_data) begin
                case (phase_reg)
                    PHASE_RED: begin
                        red_next   = data_byte;
                        phase_next = PHASE_GREEN;
                    end
                    PHASE_GREEN: begin
                        green_next = data_byte;
                        phase_next = PHASE_BLUE;
                    end
                    default: begin
                        phase_next = PHASE_RED;
                        if (hit) begin
                            res_valid = 1'b1;
                            res = '{event_kind: EV_PIXEL, pixel_index: hit_idx,
                                    red: red_reg, green: green_reg, blue: data_byte};
                        end
                        if (pix_cnt_reg != COUNTER_MAX) begin
                            pix_cnt_next = pix_cnt_reg + PIX_W'(1);
                        end
                    end
                endcase
            end

            if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + POS_W'(1);
            end

            if (last_byte) begin
                poll = !res_valid && hdr_ok_next && (pos_reg >= POS_OPCODE_HI)
                       && (opcode_next == OP_POLL);
                if (poll) begin
                    res_valid = 1'b1;
                    res = '{event_kind: EV_POLL, pixel_index: '0,
                            red: '0, green: '0, blue: '0};
                end
                pos_next     = '0;
                hdr_ok_next  = 1'b1;
                opcode_next  = '0;
                univ_next    = '0;
                phase_next   = PHASE_RED;
                red_next     = '0;
                green_next   = '0;
                pix_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            hdr_ok_reg  <= 1'b1;
            opcode_reg  <= '0;
            univ_reg    <= '0;
            phase_reg   <= PHASE_RED;
            red_reg     <= '0;
            green_reg   <= '0;
            pix_cnt_reg <= '0;
        end else begin
            pos_reg     <= pos_next;
            hdr_ok_reg  <= hdr_ok_next;
            opcode_reg  <= opcode_next;
            univ_reg    <= univ_next;
            phase_reg   <= phase_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            pix_cnt_reg <= pix_cnt_next;
        end
    end

endmodule

// ----- tb/artnet_dmx_to_pixel_parser_top_tb.sv -----
`timescale 1ns / 1ps

module artnet_dmx_to_pixel_parser_top_tb;
    import artdmx_pkg::*;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned RAND_PHASES  = 6;
    localparam int unsigned PHASE_BYTES  = 20;
    localparam int unsigned DIR_ROWS     = 24;

    localparam logic [15:0] OP_UNKNOWN_HI = 16'hFFFF;
    localparam logic [15:0] OP_UNKNOWN_LO = 16'h0000;

    localparam result_t NO_RES        = '0;
    localparam result_t POLL_RES      = '{EV_POLL, 9'd0, 8'h00, 8'h00, 8'h00};
    localparam result_t PIX_FIRST_FF  = '{EV_PIXEL, 9'd0, 8'hFF, 8'hFF, 8'hFF};
    localparam result_t PIX_FIRST_00  = '{EV_PIXEL, 9'd0, 8'h00, 8'h00, 8'h00};
    localparam result_t PIX_SECOND_FF = '{EV_PIXEL, 9'd170, 8'hFF, 8'hFF, 8'hFF};

    // CHK_MODEL: predicted; CHK_NONE: no event; CHK_GIVEN: given event on last byte
    typedef enum logic [1:0] {
        CHK_MODEL = 2'd0,
        CHK_NONE  = 2'd1,
        CHK_GIVEN = 2'd2
    } row_check_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        row_check_t        chk;
        result_t           res;
    } byte_item_t;

    typedef struct {
        logic [15:0] first_u;
        logic [15:0] second_u;
        logic        id_ok;
        logic [15:0] op;
        logic [15:0] uni;
        int unsigned len;
        int          fill;
        row_check_t  chk;
        result_t     res;
    } dgram_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = REG_FIRST_UNIVERSE;
    logic [UNIV_W-1:0]    cfg_wr_data = '0;

    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_data_byte = '0;
    logic              s_last_byte = 1'b0;
    byte_item_t        s_item      = '0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_event_kind;
    logic [PIX_W-1:0]  m_pixel_index;
    logic [BYTE_W-1:0] m_red;
    logic [BYTE_W-1:0] m_green;
    logic [BYTE_W-1:0] m_blue;

    // parser state as seen by the predictor
    logic [POS_W-1:0]  rx_pos      = '0;
    logic              id_good     = 1'b1;
    logic [15:0]       rx_opcode   = '0;
    logic [15:0]       rx_universe = '0;
    logic [1:0]        color_sel   = PHASE_RED;
    logic [BYTE_W-1:0] held_r      = '0;
    logic [BYTE_W-1:0] held_g      = '0;
    logic [PIX_W-1:0]  pix_cnt     = '0;
    logic [15:0]       univ_first  = FIRST_UNIVERSE_RST;
    logic [15:0]       univ_second = SECOND_UNIVERSE_RST;

    byte_item_t  byte_q [$];
    result_t     event_q [$];
    dgram_row_t  dir_rows [DIR_ROWS];

    int unsigned pushed_cnt    = 0;
    int unsigned accepted_cnt  = 0;
    int unsigned err_cnt       = 0;
    int unsigned stall_cycles  = 0;
    int unsigned send_idle_pct = 31;
    int unsigned recv_idle_pct = 70;
    int unsigned hold_requests = 0;

    artnet_dmx_to_pixel_parser_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_pixel_index (m_pixel_index),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic is_last,
                              output logic hit, output result_t ev);
        logic [POS_W-1:0] p;
        int unsigned      idx;
        p   = rx_pos;
        hit = 1'b0;
        ev  = NO_RES;
        idx = 0;
        if (p < POS_ID_LEN) begin
            if (b != ART_ID[p[2:0]]) id_good = 1'b0;
        end else if (p == POS_OPCODE_LO) begin
            rx_opcode[7:0] = b;
        end else if (p == POS_OPCODE_HI) begin
            rx_opcode[15:8] = b;
        end else if (p == POS_UNIV_LO) begin
            rx_universe[7:0] = b;
        end else if (p == POS_UNIV_HI) begin
            rx_universe[15:8] = b;
        end else if (p >= POS_DATA_START && p < MAX_FRAME_DEF && id_good &&
                     rx_opcode == OPC_ARTDMX) begin
            case (color_sel)
                PHASE_RED: begin
                    held_r    = b;
                    color_sel = PHASE_GREEN;
                end
                PHASE_GREEN: begin
                    held_g    = b;
                    color_sel = PHASE_BLUE;
                end
                default: begin
                    color_sel = PHASE_RED;
                    if (rx_universe == univ_first) begin
                        if (pix_cnt < SPLIT_DEF) begin
                            hit = 1'b1;
                            idx = 32'(pix_cnt);
                        end
                    end else if (rx_universe == univ_second) begin
                        if (SPLIT_DEF + pix_cnt < PIXEL_COUNT_DEF) begin
                            hit = 1'b1;
                            idx = SPLIT_DEF + pix_cnt;
                        end
                    end
                    if (hit) begin
                        ev.event_kind  = EV_PIXEL;
                        ev.pixel_index = PIX_W'(idx);
                        ev.red         = held_r;
                        ev.green       = held_g;
                        ev.blue        = b;
                    end
                    if (pix_cnt != COUNTER_MAX) pix_cnt++;
                end
            endcase
        end
        if (p != POS_MAX) rx_pos = p + 1'b1;
        if (is_last) begin
            if (!hit && id_good && p >= POS_OPCODE_HI && rx_opcode == OP_POLL) begin
                hit = 1'b1;
                ev  = POLL_RES;
            end
            rx_pos      = '0;
            id_good     = 1'b1;
            rx_opcode   = '0;
            rx_universe = '0;
            color_sel   = PHASE_RED;
            held_r      = '0;
            held_g      = '0;
            pix_cnt     = '0;
        end
    endtask

    task automatic queue_dgram(input logic id_ok, input logic [15:0] op,
                               input logic [15:0] uni, input int unsigned len,
                               input int fill, input row_check_t chk, input result_t res);
        byte_item_t        it;
        int unsigned       bad_pos;
        logic [BYTE_W-1:0] bad_mask;
        bad_pos  = $urandom_range(7);
        bad_mask = 8'($urandom_range(1, 255));
        for (int unsigned i = 0; i < len; i++) begin
            if (i < POS_ID_LEN) begin
                it.data = ART_ID[i] ^ ((!id_ok && i == bad_pos) ? bad_mask : 8'h00);
            end else if (i == POS_OPCODE_LO) begin
                it.data = op[7:0];
            end else if (i == POS_OPCODE_HI) begin
                it.data = op[15:8];
            end else if (i == POS_UNIV_LO) begin
                it.data = uni[7:0];
            end else if (i == POS_UNIV_HI) begin
                it.data = uni[15:8];
            end else if (i < POS_DATA_START || fill < 0) begin
                it.data = 8'($urandom);
            end else begin
                it.data = 8'(fill);
            end
            it.last = (i == len - 1);
            it.chk  = chk;
            it.res  = res;
            byte_q.push_back(it);
            pushed_cnt++;
        end
    endtask

    task automatic settle();
        while (accepted_cnt != pushed_cnt || event_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_universes(input logic [15:0] first_u, input logic [15:0] second_u);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_FIRST_UNIVERSE;
        cfg_wr_data <= first_u;
        @(posedge aclk);
        cfg_index   <= REG_SECOND_UNIVERSE;
        cfg_wr_data <= second_u;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        univ_first  = first_u;
        univ_second = second_u;
    endtask

    function automatic logic [15:0] pick_universe();
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 8));
            default: return 16'($urandom);
        endcase
    endfunction

    // byte source
    always @(posedge aclk) begin
        byte_item_t nxt;
        if (aresetn && (!s_valid || s_ready)) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = byte_q.pop_front();
                s_item      <= nxt;
                s_valid     <= 1'b1;
                s_data_byte <= nxt.data;
                s_last_byte <= nxt.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // event sink, with an occasional long hold-off
    initial begin
        int unsigned hold_served;
        int unsigned hold_left;
        hold_served = 0;
        hold_left   = 0;
        forever begin
            @(posedge aclk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        logic    hit;
        logic    in_xfer;
        logic    out_xfer;
        result_t got;
        result_t want;
        in_xfer  = aresetn && s_valid && s_ready;
        out_xfer = aresetn && m_valid && m_ready;
        if (in_xfer) begin
            accepted_cnt++;
            parse_byte(s_data_byte, s_last_byte, hit, got);
            case (s_item.chk)
                CHK_MODEL: if (hit) event_q.push_back(got);
                CHK_GIVEN: if (s_item.last) event_q.push_back(s_item.res);
                default: ;
            endcase
        end
        if (out_xfer) begin
            if (event_q.size() == 0) begin
                note_error($sformatf("unexpected event transfer: %0d/%0d/%02h/%02h/%02h",
                           m_event_kind, m_pixel_index, m_red, m_green, m_blue));
            end else begin
                want = event_q.pop_front();
                if (m_event_kind !== want.event_kind || m_pixel_index !== want.pixel_index ||
                    m_red !== want.red || m_green !== want.green || m_blue !== want.blue) begin
                    note_error($sformatf(
                        "event mismatch: expected %0d/%0d/%02h/%02h/%02h got %0d/%0d/%02h/%02h/%02h",
                        want.event_kind, want.pixel_index, want.red, want.green, want.blue,
                        m_event_kind, m_pixel_index, m_red, m_green, m_blue));
                end
            end
        end
        if (!aresetn || in_xfer || out_xfer) stall_cycles = 0;
        else stall_cycles++;
    end

    initial begin
        wait (aresetn);
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [15:0] first_u;
        logic [15:0] second_u;
        logic [15:0] op;
        logic [15:0] uni;
        logic        id_ok;
        int unsigned len;
        int unsigned ntrip;
        int unsigned sel;
        int unsigned phase_start;

        dir_rows = '{
            '{16'd1, 16'd2, 1'b1, OP_POLL, 16'd0, 10, -1, CHK_GIVEN, POLL_RES},
            '{16'd1, 16'd2, 1'b1, OP_POLL, 16'd0, 9, -1, CHK_NONE, NO_RES},
            '{16'd1, 16'd2, 1'b0, OP_POLL, 16'd0, 12, -1, CHK_NONE, NO_RES},
            '{16'd1, 16'd2, 1'b1, OPC_ARTDMX, 16'd1, 21, 255, CHK_GIVEN, PIX_FIRST_FF},
            '{16'd1, 16'd2, 1'b1, OPC_ARTDMX, 16'd1, 21, 0, CHK_GIVEN, PIX_FIRST_00},
            '{16'd1, 16'd2, 1'b1, OPC_ARTDMX, 16'd2, 21, 255, CHK_GIVEN, PIX_SECOND_FF},
            '{16'd1, 16'd2, 1'b1, OPC_ARTDMX, 16'd2, 20, -1, CHK_NONE, NO_RES},
            '{16'd1, 16'd2, 1'b1, OPC_ARTDMX, 16'd1, 17, -1, CHK_NONE, NO_RES},
            '{16'd1, 16'd2, 1'b1, OP_UNKNOWN_HI, 16'd1, 30, -1, CHK_NONE, NO_RES},
            '{16'd1, 16'd2, 1'b1, OP_UNKNOWN_LO, 16'd1, 24, -1, CHK_NONE, NO_RES},
            '{16'd1, 16'd2, 1'b1, OPC_ARTDMX, 16'd3, 30, -1, CHK_NONE, NO_RES},
            '{16'd1, 16'd2, 1'b0, OPC_ARTDMX, 16'd1, 30, -1, CHK_NONE, NO_RES},
            '{16'd1, 16'd2, 1'b1, OPC_ARTDMX, 16'd1, 531, -1, CHK_MODEL, NO_RES},
            '{16'd1, 16'd2, 1'b1, OPC_ARTDMX, 16'd2, 411, -1, CHK_MODEL, NO_RES},
            '{16'd1, 16'd2, 1'b1, OPC_ARTDMX, 16'd1, 30, -1, CHK_MODEL, NO_RES},
            '{16'd1, 16'd2, 1'b1, OPC_ARTDMX, 16'd1, 40, -1, CHK_MODEL, NO_RES},
            '{16'd1, 16'd2, 1'b1, OP_POLL, 16'd0, 40, -1, CHK_GIVEN, POLL_RES},
            '{16'h0000, 16'hFFFF, 1'b1, OPC_ARTDMX, 16'h0000, 33, -1, CHK_MODEL, NO_RES},
            '{16'h0000, 16'hFFFF, 1'b1, OPC_ARTDMX, 16'hFFFF, 33, -1, CHK_MODEL, NO_RES},
            '{16'h0000, 16'hFFFF, 1'b1, OPC_ARTDMX, 16'd1, 24, -1, CHK_NONE, NO_RES},
            '{16'hA5A5, 16'hA5A5, 1'b1, OPC_ARTDMX, 16'hA5A5, 60, -1, CHK_MODEL, NO_RES},
            '{16'hA5A5, 16'hA5A5, 1'b1, OP_POLL, 16'd0, 10, -1, CHK_GIVEN, POLL_RES},
            '{16'hFFFF, 16'h0000, 1'b1, OPC_ARTDMX, 16'h0000, 30, -1, CHK_MODEL, NO_RES},
            '{16'hFFFF, 16'h0000, 1'b1, OPC_ARTDMX, 16'hFFFF, 30, -1, CHK_MODEL, NO_RES}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].first_u != univ_first || dir_rows[r].second_u != univ_second) begin
                settle();
                write_universes(dir_rows[r].first_u, dir_rows[r].second_u);
            end
            queue_dgram(dir_rows[r].id_ok, dir_rows[r].op, dir_rows[r].uni, dir_rows[r].len,
                        dir_rows[r].fill, dir_rows[r].chk, dir_rows[r].res);
        end

        for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            case (ph / 2)
                0: begin
                    send_idle_pct = 31;
                    recv_idle_pct = 70;
                end
                1: begin
                    send_idle_pct = 70;
                    recv_idle_pct = 31;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            first_u  = pick_universe();
            second_u = ($urandom_range(3) == 0) ? first_u : pick_universe();
            write_universes(first_u, second_u);
            // stall the sink long enough to back the parser up into its input
            if (ph == 2) begin
                hold_requests++;
                queue_dgram(1'b1, OPC_ARTDMX, univ_first, 42, -1, CHK_MODEL, NO_RES);
            end
            phase_start = pushed_cnt;
            while (pushed_cnt < phase_start + PHASE_BYTES) begin
                sel   = $urandom_range(99);
                op    = OPC_ARTDMX;
                id_ok = 1'b1;
                ntrip = $urandom_range(99);
                uni   = (ntrip < 45) ? univ_first :
                        (ntrip < 80) ? univ_second : 16'($urandom);
                if (sel < 70) begin
                    ntrip = $urandom_range(12);
                    len   = POS_DATA_START + 3 * ntrip;
                    if ($urandom_range(2) == 0) len += $urandom_range(1, 2);
                end else if (sel < 82) begin
                    op  = OP_POLL;
                    len = ($urandom_range(4) == 0) ? $urandom_range(1, 9)
                                                   : $urandom_range(10, 24);
                end else if (sel < 90) begin
                    if ($urandom_range(1)) begin
                        id_ok = 1'b0;
                        len   = $urandom_range(1, 40);
                    end else begin
                        len = $urandom_range(1, 17);
                    end
                end else begin
                    op    = 16'($urandom);
                    id_ok = $urandom_range(1);
                    len   = $urandom_range(1, 40);
                end
                queue_dgram(id_ok, op, uni, len, -1, CHK_MODEL, NO_RES);
            end
        end

        settle();
        if (err_cnt == 0 && event_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
